@@ rtl/sdpg_pkg.sv @@
`default_nettype none

package sdpg_pkg;

    localparam int AMOUNT_W = 16;
    localparam int REF_W    = 16;
    localparam int DIV_W    = 16;
    localparam int MS_W     = 2;
    localparam int MAG_W    = AMOUNT_W + 1;
    localparam int PROD_W   = MAG_W + REF_W;
    localparam int STEP_W   = 35;
    localparam int REM_W    = 34;
    localparam int SHIFT_W  = STEP_W + 1;
    localparam int CFG_W    = 16;

    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_DISPENSE = 2'd1,
        ACT_START    = 2'd2,
        ACT_STOP     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_REF_AMOUNT     = 2'd0,
        CFG_SPEED_DIV      = 2'd1,
        CFG_MICROSTEP_MODE = 2'd2,
        CFG_DRIVER_ENABLE  = 2'd3
    } t_cfg_idx;

    localparam logic [1:0] DIR_KEEP = 2'd0;
    localparam logic [1:0] DIR_SIGN = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [REF_W-1:0] REF_AMOUNT_RST = REF_W'(10);
    localparam logic [DIV_W-1:0] SPEED_DIV_RST  = DIV_W'(1);
    localparam logic [MS_W-1:0]  MS_MODE_RST    = MS_W'(1);

    typedef struct packed {
        t_action           action;
        logic              negative;
        logic [1:0]        dir_mode;
        logic [PROD_W-1:0] product;
    } t_cmd;

    typedef struct packed {
        logic              step_level;
        logic              dir_down;
        logic              awake;
        logic              dispensing_flag;
        logic              continuous_flag;
        logic [REM_W-1:0]  remaining_steps;
        logic [MS_W-1:0]   ms_pins;
        logic              enable_n;
        logic              status;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/stepper_dispense_pulse_generator.sv @@
// Channel   Direction  Handshake                   Payload
// in        to block   i_in_valid / o_in_stall     i_action, i_amount, i_dir_mode
// out       from block o_out_valid / i_out_stall   o_step_level .. o_status
// cfg       to block   i_cfg_we                    i_cfg_idx, i_cfg_data
//
// One transaction per clock sustained while the result side does not stall.
// Stage one registers |amount| times ref_amount (the single multiplier); stage two
// applies the microstep shift, updates the stepper state and loads the result register.
// Reset is synchronous; config returns to ref 10, divider 1, half step, driver enabled.
// A stall on the result side holds both stages and backs up to o_in_stall.
`default_nettype none

module stepper_dispense_pulse_generator
    import sdpg_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [1:0]          i_action,
    input  wire logic signed [AMOUNT_W-1:0] i_amount,
    input  wire logic [1:0]          i_dir_mode,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_step_level,
    output logic                     o_dir_down,
    output logic                     o_awake,
    output logic                     o_dispensing_flag,
    output logic                     o_continuous_flag,
    output logic [REM_W-1:0]         o_remaining_steps,
    output logic [MS_W-1:0]          o_ms_pins,
    output logic                     o_enable_n,
    output logic                     o_status,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [CFG_W-1:0]    i_cfg_data
);

    logic [REF_W-1:0] r_ref_amount;
    logic [DIV_W-1:0] r_speed_div;
    logic [MS_W-1:0]  r_ms_mode;
    logic             r_driver_enable;
    logic             cmd_valid;
    logic             cmd_take;
    t_cmd             cmd;
    t_result          result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_amount    <= REF_AMOUNT_RST;
            r_speed_div     <= SPEED_DIV_RST;
            r_ms_mode       <= MS_MODE_RST;
            r_driver_enable <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_REF_AMOUNT:     r_ref_amount    <= i_cfg_data[REF_W-1:0];
                CFG_SPEED_DIV:      r_speed_div     <= i_cfg_data[DIV_W-1:0];
                CFG_MICROSTEP_MODE: r_ms_mode       <= i_cfg_data[MS_W-1:0];
                CFG_DRIVER_ENABLE:  r_driver_enable <= i_cfg_data[0];
                default:            r_driver_enable <= r_driver_enable;
            endcase
        end
    end

    sdpg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_action     (i_action),
        .i_amount     (i_amount),
        .i_dir_mode   (i_dir_mode),
        .i_ref_amount (r_ref_amount),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_take   (cmd_take)
    );

    sdpg_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_take      (cmd_take),
        .i_speed_div     (r_speed_div),
        .i_ms_mode       (r_ms_mode),
        .i_driver_enable (r_driver_enable),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_result        (result)
    );

    assign o_step_level      = result.step_level;
    assign o_dir_down        = result.dir_down;
    assign o_awake           = result.awake;
    assign o_dispensing_flag = result.dispensing_flag;
    assign o_continuous_flag = result.continuous_flag;
    assign o_remaining_steps = result.remaining_steps;
    assign o_ms_pins         = result.ms_pins;
    assign o_enable_n        = result.enable_n;
    assign o_status          = result.status;

endmodule

`default_nettype wire

@@ rtl/sdpg_front.sv @@
`default_nettype none

module sdpg_front
    import sdpg_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [1:0]          i_action,
    input  wire logic [AMOUNT_W-1:0] i_amount,
    input  wire logic [1:0]          i_dir_mode,
    input  wire logic [REF_W-1:0]    i_ref_amount,
    output logic                     o_cmd_valid,
    output t_cmd                     o_cmd,
    input  wire logic                i_cmd_take
);

    logic              r_valid;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic              load;
    logic              negative;
    logic [MAG_W-1:0]  magnitude;

    assign negative  = i_amount[AMOUNT_W-1];
    assign magnitude = negative ? MAG_W'((MAG_W'(1) << AMOUNT_W) - {1'b0, i_amount})
                                : {1'b0, i_amount};

    always_comb begin
        n_cmd.action   = t_action'(i_action);
        n_cmd.negative = negative;
        n_cmd.dir_mode = i_dir_mode;
        n_cmd.product  = PROD_W'(magnitude) * PROD_W'(i_ref_amount);
    end

    assign load        = !r_valid || i_cmd_take;
    assign o_stall     = !load;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sdpg_core.sv @@
`default_nettype none

module sdpg_core
    import sdpg_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cmd_valid,
    input  wire t_cmd             i_cmd,
    output logic                  o_cmd_take,
    input  wire logic [DIV_W-1:0] i_speed_div,
    input  wire logic [MS_W-1:0]  i_ms_mode,
    input  wire logic             i_driver_enable,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output t_result               o_result
);

    logic [STEP_W-1:0] r_step_count, n_step_count;
    logic [DIV_W-1:0]  r_div_count,  n_div_count;
    logic              r_step_line,  n_step_line;
    logic              r_running,    n_running;
    logic              r_endless,    n_endless;
    logic              r_dir_down,   n_dir_down;
    logic              r_awake,      n_awake;
    logic              n_status;
    logic              r_out_valid;
    t_result           r_result;
    t_result           n_result;
    logic              take;
    logic [STEP_W-1:0] loaded_steps;

    assign take       = i_cmd_valid && (!r_out_valid || !i_stall);
    assign o_cmd_take = take;
    assign loaded_steps = STEP_W'({{(SHIFT_W-PROD_W){1'b0}}, i_cmd.product} << i_ms_mode);

    always_comb begin
        n_step_count = r_step_count;
        n_div_count  = r_div_count;
        n_step_line  = r_step_line;
        n_running    = r_running;
        n_endless    = r_endless;
        n_dir_down   = r_dir_down;
        n_awake      = r_awake;
        n_status     = 1'b0;
        unique case (i_cmd.action)
            ACT_TICK: begin
                if (r_running) begin
                    if (r_div_count >= i_speed_div) begin
                        n_div_count = '0;
                        if (r_endless) begin
                            n_step_line = !r_step_line;
                        end else if (r_step_count != '0) begin
                            n_step_line = !r_step_line;
                            if (!r_step_line) begin
                                n_step_count = r_step_count - STEP_W'(1);
                            end
                        end else begin
                            n_running = 1'b0;
                            n_awake   = 1'b0;
                        end
                    end else begin
                        n_div_count = r_div_count + DIV_W'(1);
                    end
                end
            end
            ACT_DISPENSE, ACT_START: begin
                if (r_running) begin
                    n_status = 1'b1;
                end else begin
                    if (i_cmd.dir_mode == DIR_SIGN) begin
                        n_dir_down = !i_cmd.negative;
                    end else if (i_cmd.dir_mode == DIR_DOWN) begin
                        n_dir_down = 1'b1;
                    end
                    n_running = 1'b1;
                    n_awake   = 1'b1;
                    if (i_cmd.action == ACT_START) begin
                        n_step_count = '0;
                        n_endless    = 1'b1;
                    end else begin
                        n_step_count = loaded_steps;
                    end
                end
            end
            ACT_STOP: begin
                n_endless    = 1'b0;
                n_running    = 1'b0;
                n_awake      = 1'b0;
                n_step_count = '0;
            end
            default: begin
                n_status = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_result.step_level      = n_step_line;
        n_result.dir_down        = n_dir_down;
        n_result.awake           = n_awake;
        n_result.dispensing_flag = n_running;
        n_result.continuous_flag = n_endless;
        n_result.remaining_steps = n_step_count[REM_W-1:0];
        n_result.ms_pins         = i_ms_mode;
        n_result.enable_n        = !i_driver_enable;
        n_result.status          = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count <= '0;
            r_div_count  <= '0;
            r_step_line  <= 1'b0;
            r_running    <= 1'b0;
            r_endless    <= 1'b0;
            r_dir_down   <= 1'b1;
            r_awake      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (take) begin
                r_step_count <= n_step_count;
                r_div_count  <= n_div_count;
                r_step_line  <= n_step_line;
                r_running    <= n_running;
                r_endless    <= n_endless;
                r_dir_down   <= n_dir_down;
                r_awake      <= n_awake;
            end
            if (!r_out_valid || !i_stall) begin
                r_out_valid <= i_cmd_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

@@ rtl/sdpg_checker.sv @@
`default_nettype none

module sdpg_checker
    import sdpg_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire logic             o_awake,
    input wire logic             o_dispensing_flag,
    input wire logic             o_continuous_flag,
    input wire logic [REM_W-1:0] o_remaining_steps,
    input wire logic             o_status
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result valid dropped while stalled");

    a_busy_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_dispensing_flag)
        else $error("busy status while idle");

    a_cont_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_continuous_flag |-> o_dispensing_flag)
        else $error("continuous flag without run");

    a_steps_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_remaining_steps != '0) |-> o_dispensing_flag)
        else $error("steps pending while idle");

    a_awake_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_awake == o_dispensing_flag))
        else $error("sleep pin out of step with run");

endmodule

bind stepper_dispense_pulse_generator sdpg_checker u_sdpg_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_awake           (o_awake),
    .o_dispensing_flag (o_dispensing_flag),
    .o_continuous_flag (o_continuous_flag),
    .o_remaining_steps (o_remaining_steps),
    .o_status          (o_status)
);

`default_nettype wire

@@ sim/stepper_dispense_pulse_generator_tb.sv @@
`timescale 1ns / 100ps

module stepper_dispense_pulse_generator_tb;
    import sdpg_pkg::*;

    localparam int          CLK_HALF   = 6;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          TICK_CAP   = 120;
    localparam logic [1:0]  DIR_RSVD   = 2'd3;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [1:0]               i_action;
    logic signed [AMOUNT_W-1:0] i_amount;
    logic [1:0]               i_dir_mode;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_step_level;
    logic                     o_dir_down;
    logic                     o_awake;
    logic                     o_dispensing_flag;
    logic                     o_continuous_flag;
    logic [REM_W-1:0]         o_remaining_steps;
    logic [MS_W-1:0]          o_ms_pins;
    logic                     o_enable_n;
    logic                     o_status;
    logic                     i_cfg_we;
    logic [1:0]               i_cfg_idx;
    logic [CFG_W-1:0]         i_cfg_data;

    stepper_dispense_pulse_generator u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_amount          (i_amount),
        .i_dir_mode        (i_dir_mode),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_step_level      (o_step_level),
        .o_dir_down        (o_dir_down),
        .o_awake           (o_awake),
        .o_dispensing_flag (o_dispensing_flag),
        .o_continuous_flag (o_continuous_flag),
        .o_remaining_steps (o_remaining_steps),
        .o_ms_pins         (o_ms_pins),
        .o_enable_n        (o_enable_n),
        .o_status          (o_status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    // register copies
    logic [REF_W-1:0]  ref_cfg = REF_AMOUNT_RST;
    logic [DIV_W-1:0]  div_cfg = SPEED_DIV_RST;
    logic [MS_W-1:0]   ms_cfg  = MS_MODE_RST;
    logic              en_cfg  = 1'b1;

    // stepper state copies
    logic [STEP_W-1:0] step_cnt   = '0;
    logic [DIV_W-1:0]  div_cnt    = '0;
    logic              pulse_line = 1'b0;
    logic              run_active = 1'b0;
    logic              endless_run = 1'b0;
    logic              dir_dn     = 1'b1;
    logic              drv_awake  = 1'b0;

    t_result pending_results[$];
    t_result want_res;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_cnt = 0;
    int item_cnt = 0;
    int checked_cnt = 0;
    int busy_cnt = 0;
    int run_end_cnt = 0;
    int setting_cnt = 0;
    int cycle_cnt = 0;

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic t_result next_pin_state(t_action act, logic [15:0] amt, logic [1:0] dm);
        t_result     r;
        logic [16:0] mag;
        logic [35:0] prod;
        logic        refused;
        refused = 1'b0;
        mag = amt[15] ? (17'h10000 - {1'b0, amt}) : {1'b0, amt};
        case (act)
            ACT_TICK: begin
                if (run_active) begin
                    if (div_cnt >= div_cfg) begin
                        div_cnt = '0;
                        if (endless_run) begin
                            pulse_line = ~pulse_line;
                        end else if (step_cnt != '0) begin
                            pulse_line = ~pulse_line;
                            if (pulse_line)
                                step_cnt = step_cnt - STEP_W'(1);
                        end else begin
                            run_active = 1'b0;
                            drv_awake = 1'b0;
                            run_end_cnt++;
                        end
                    end else begin
                        div_cnt = div_cnt + DIV_W'(1);
                    end
                end
            end
            ACT_DISPENSE, ACT_START: begin
                if (run_active) begin
                    refused = 1'b1;
                    busy_cnt++;
                end else begin
                    if (dm == DIR_SIGN)
                        dir_dn = ~amt[15];
                    else if (dm == DIR_DOWN)
                        dir_dn = 1'b1;
                    if (act == ACT_DISPENSE) begin
                        prod = {19'd0, mag} * {20'd0, ref_cfg};
                        prod = prod << ms_cfg;
                        step_cnt = prod[STEP_W-1:0];
                    end else begin
                        step_cnt = '0;
                        endless_run = 1'b1;
                    end
                    run_active = 1'b1;
                    drv_awake = 1'b1;
                end
            end
            default: begin
                endless_run = 1'b0;
                run_active = 1'b0;
                drv_awake = 1'b0;
                step_cnt = '0;
            end
        endcase
        r.step_level      = pulse_line;
        r.dir_down        = dir_dn;
        r.awake           = drv_awake;
        r.dispensing_flag = run_active;
        r.continuous_flag = endless_run;
        r.remaining_steps = step_cnt[REM_W-1:0];
        r.ms_pins         = ms_cfg;
        r.enable_n        = ~en_cfg;
        r.status          = refused;
        return r;
    endfunction

    task automatic cmp_field(string fname, logic [REM_W-1:0] want, logic [REM_W-1:0] got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                err_cnt++;
                $display("%0t: result transaction with none expected", $time);
            end else begin
                want_res = pending_results.pop_front();
                checked_cnt++;
                cmp_field("step_level", want_res.step_level, o_step_level);
                cmp_field("dir_down", want_res.dir_down, o_dir_down);
                cmp_field("awake", want_res.awake, o_awake);
                cmp_field("dispensing_flag", want_res.dispensing_flag, o_dispensing_flag);
                cmp_field("continuous_flag", want_res.continuous_flag, o_continuous_flag);
                cmp_field("remaining_steps", want_res.remaining_steps, o_remaining_steps);
                cmp_field("ms_pins", want_res.ms_pins, o_ms_pins);
                cmp_field("enable_n", want_res.enable_n, o_enable_n);
                cmp_field("status", want_res.status, o_status);
            end
        end
    end

    task automatic send_cmd(t_action act, logic [15:0] amt, logic [1:0] dm);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_amount   <= amt;
        i_dir_mode <= dm;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pending_results.push_back(next_pin_state(act, amt, dm));
        item_cnt++;
    endtask

    task automatic tick_n(int n);
        repeat (n)
            send_cmd(ACT_TICK, 16'($urandom), 2'($urandom));
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_REF_AMOUNT:     ref_cfg = val;
            CFG_SPEED_DIV:      div_cfg = val;
            CFG_MICROSTEP_MODE: ms_cfg = val[MS_W-1:0];
            default:            en_cfg = val[0];
        endcase
    endtask

    // drain in-flight transactions, then load all four registers
    task automatic program_regs(logic [15:0] ref_v, logic [15:0] div_v, logic [1:0] ms_v,
                                logic en_v);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        write_reg(CFG_REF_AMOUNT, ref_v);
        write_reg(CFG_SPEED_DIV, div_v);
        write_reg(CFG_MICROSTEP_MODE, {14'd0, ms_v});
        write_reg(CFG_DRIVER_ENABLE, {15'd0, en_v});
        i_cfg_we <= 1'b0;
        setting_cnt++;
    endtask

    task automatic set_traffic(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_reset_defaults();
        tick_n(1);
        send_cmd(ACT_STOP, 16'h0000, DIR_KEEP);
        send_cmd(ACT_DISPENSE, 16'h0001, DIR_SIGN);
        send_cmd(ACT_DISPENSE, 16'h7FFF, DIR_SIGN);
        send_cmd(ACT_START, 16'h8000, DIR_DOWN);
        tick_n(4);
        send_cmd(ACT_STOP, 16'hFFFF, DIR_RSVD);
        send_cmd(ACT_START, 16'hFFFB, DIR_SIGN);
        tick_n(3);
        send_cmd(ACT_STOP, 16'h0000, DIR_KEEP);
        send_cmd(ACT_DISPENSE, 16'h0000, DIR_DOWN);
        tick_n(3);
    endtask

    task automatic test_config_extremes();
        program_regs(16'hFFFF, 16'd0, 2'd3, 1'b0);
        send_cmd(ACT_DISPENSE, 16'h8000, DIR_SIGN);
        tick_n(2);
        send_cmd(ACT_STOP, 16'h5555, DIR_KEEP);
        program_regs(16'd0, 16'hFFFF, 2'd0, 1'b1);
        send_cmd(ACT_DISPENSE, 16'h7FFF, DIR_RSVD);
        tick_n(3);
        send_cmd(ACT_STOP, 16'hAAAA, DIR_DOWN);
    endtask

    task automatic test_counted_dispense(int n, logic [15:0] ref_v, logic [15:0] div_v,
                                         logic [1:0] ms_v, logic en_v);
        int first;
        int ticks;
        logic [15:0] amt;
        program_regs(ref_v, div_v, ms_v, en_v);
        first = item_cnt;
        while (item_cnt - first < n) begin
            if ($urandom_range(9) == 0) begin
                send_cmd(t_action'($urandom_range(3)), 16'($urandom), 2'($urandom));
            end else begin
                amt = 16'($urandom_range(6)) - 16'd3;
                if ($urandom_range(7) == 0)
                    amt = 16'($urandom);
                send_cmd(ACT_DISPENSE, amt, 2'($urandom));
                ticks = 0;
                while (run_active && ticks < TICK_CAP) begin
                    if ($urandom_range(15) == 0)
                        send_cmd($urandom_range(1) ? ACT_START : ACT_DISPENSE, 16'($urandom),
                                 2'($urandom));
                    else
                        tick_n(1);
                    ticks++;
                end
                if (run_active || $urandom_range(3) == 0)
                    send_cmd(ACT_STOP, 16'($urandom), 2'($urandom));
            end
        end
    endtask

    task automatic test_continuous_run(int n, logic [15:0] ref_v, logic [15:0] div_v,
                                       logic [1:0] ms_v, logic en_v);
        int first;
        int ticks;
        program_regs(ref_v, div_v, ms_v, en_v);
        first = item_cnt;
        while (item_cnt - first < n) begin
            send_cmd(ACT_START, 16'($urandom), 2'($urandom));
            ticks = $urandom_range(30);
            repeat (ticks) begin
                if ($urandom_range(9) == 0)
                    send_cmd($urandom_range(1) ? ACT_START : ACT_DISPENSE, 16'($urandom),
                             2'($urandom));
                else
                    tick_n(1);
            end
            send_cmd(ACT_STOP, 16'($urandom), 2'($urandom));
            if ($urandom_range(3) == 0)
                send_cmd($urandom_range(1) ? ACT_STOP : ACT_TICK, 16'($urandom), 2'($urandom));
        end
    endtask

    task automatic test_random_mix(int n, logic [15:0] ref_v, logic [15:0] div_v,
                                   logic [1:0] ms_v, logic en_v);
        int pick;
        t_action act;
        program_regs(ref_v, div_v, ms_v, en_v);
        repeat (n) begin
            pick = $urandom_range(99);
            act = (pick < 60) ? ACT_TICK : (pick < 75) ? ACT_DISPENSE :
                  (pick < 85) ? ACT_START : ACT_STOP;
            send_cmd(act, 16'($urandom), 2'($urandom));
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_action    = ACT_TICK;
        i_amount    = '0;
        i_dir_mode  = DIR_KEEP;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_REF_AMOUNT;
        i_cfg_data  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_traffic(29, 67);
        test_reset_defaults();
        test_config_extremes();
        test_counted_dispense(350, 16'd1, 16'd1, 2'd1, 1'b1);

        set_traffic(67, 29);
        test_continuous_run(250, 16'd3, 16'd0, 2'd2, 1'b0);
        test_counted_dispense(350, 16'd2, 16'd0, 2'd0, 1'b0);

        set_traffic(0, 0);
        test_random_mix(200, 16'h00FF, 16'd3, 2'd1, 1'b1);
        test_counted_dispense(250, 16'd1, 16'd2, 2'd2, 1'b1);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Ran %0d commands over %0d register settings, %0d results checked",
                 item_cnt, setting_cnt, checked_cnt);
        $display("%0d commands refused as busy, %0d counted runs ran out", busy_cnt,
                 run_end_cnt);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
